>>> design/bslm_pkg.sv
// bslm_pkg: shared types, codes and the level mapping of the battery monitor
// used by battery_stability_and_level_monitor_core and bslm_checker
package bslm_pkg;

  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_RAPID_CHANGE     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RAPID_WINDOW     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPREAD_TOLERANCE = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_INSTABILITY_LIM  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_PRESENT_MIN      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_PRESENT_MAX      = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_USB_PRESENT      = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_CHARGING         = 3'd7;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_DISCONNECTED = 2'd0;
  localparam status_t STATUS_UNSTABLE     = 2'd1;
  localparam status_t STATUS_CHARGING     = 2'd2;
  localparam status_t STATUS_CONNECTED    = 2'd3;

  localparam logic [12:0] SCAN_MIN_START = 13'd4300;
  localparam logic [7:0]  RUN_MAX        = 8'd255;
  localparam logic [6:0]  LEVEL_MAX      = 7'd100;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  // piecewise charge estimate, divisions done by reciprocal multiply or by shift
  function automatic logic [6:0] level_of(input logic [15:0] v);
    logic [15:0] d;
    logic [23:0] t;
    logic [6:0]  p;
    d = 16'd0;
    t = 24'd0;
    p = 7'd0;
    if (v >= 16'd4150) begin
      d = v - 16'd4150;
      t = 24'(d) * 24'd205;
      if (d >= 16'd50) p = LEVEL_MAX;
      else p = 7'd95 + 7'(t >> 11);
    end else if (v >= 16'd4000) begin
      d = v - 16'd4000;
      t = 24'({d, 1'b0}) * 24'd2185;
      p = 7'd75 + 7'(t >> 15);
    end else if (v >= 16'd3800) begin
      d = v - 16'd3800;
      p = 7'd50 + 7'(d >> 3);
    end else if (v >= 16'd3600) begin
      d = v - 16'd3600;
      p = 7'd25 + 7'(d >> 3);
    end else if (v >= 16'd3400) begin
      d = v - 16'd3400;
      t = 24'(d) * 24'd615;
      p = 7'd10 + 7'(t >> 13);
    end else if (v >= 16'd3200) begin
      d = v - 16'd3200;
      t = 24'(d) * 24'd205;
      p = 7'd5 + 7'(t >> 13);
    end else if (v >= 16'd3000) begin
      d = v - 16'd3000;
      t = 24'(d) * 24'd205;
      p = 7'(t >> 13);
    end
    return p;
  endfunction

endpackage

>>> design/battery_stability_and_level_monitor_core.sv
// battery_stability_and_level_monitor_core: sample window memory, rapid jump,
// spread, presence, level and charging judgment; depends on bslm_pkg
// requests are taken one at a time, since the window is scanned through the single read
//   port of the sample memory; a new one is taken only after the result is registered
// reset: synchronous, active low; window valid bits clear at once, no sweep
module battery_stability_and_level_monitor_core #(
  parameter int WINDOW_DEPTH = 8,
  parameter int MV_BITS      = 13
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [MV_BITS-1:0]                   in_battery_mv,
  input  logic [MV_BITS-1:0]                   in_usb_mv,
  input  logic [31:0]                          in_now_ms,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_present,
  output logic [6:0]                           out_level_percent,
  output logic                                 out_sample_stable,
  output logic                                 out_rapid_change,
  output logic                                 out_charging,
  output bslm_pkg::status_t                    out_status,
  input  logic                                 cfg_wr_en,
  input  logic [bslm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [bslm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import bslm_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int WB = (MV_BITS > 13) ? MV_BITS : 13;
  localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_DEPTH - 1);

  // configuration
  logic [12:0] rapid_change_r, spread_tol_r, present_min_r, present_max_r;
  logic [12:0] usb_present_r, charging_mv_r;
  logic [15:0] rapid_window_r;
  logic [7:0]  inst_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rapid_change_r <= 13'd300;
      rapid_window_r <= 16'd5000;
      spread_tol_r   <= 13'd200;
      inst_limit_r   <= 8'd3;
      present_min_r  <= 13'd2500;
      present_max_r  <= 13'd4500;
      usb_present_r  <= 13'd4000;
      charging_mv_r  <= 13'd4100;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_RAPID_CHANGE:     rapid_change_r <= cfg_data[12:0];
        REG_RAPID_WINDOW:     rapid_window_r <= cfg_data;
        REG_SPREAD_TOLERANCE: spread_tol_r   <= cfg_data[12:0];
        REG_INSTABILITY_LIM:  inst_limit_r   <= cfg_data[7:0];
        REG_PRESENT_MIN:      present_min_r  <= cfg_data[12:0];
        REG_PRESENT_MAX:      present_max_r  <= cfg_data[12:0];
        REG_USB_PRESENT:      usb_present_r  <= cfg_data[12:0];
        REG_CHARGING:         charging_mv_r  <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // control state
  state_t            state_r, state_nxt;
  logic [AW-1:0]     ptr_r, scan_cnt_r;
  logic [WINDOW_DEPTH-1:0] vbits_r;
  logic              rd_pend_r;
  logic [MV_BITS-1:0] last_stable_r;
  logic [31:0]       last_jump_r;
  logic [7:0]        run_r;
  logic              link_r;
  logic              out_valid_r;

  // request and scan data
  logic [MV_BITS-1:0] v_r, usb_r;
  logic [31:0]        now_r;
  logic [MV_BITS-1:0] rd_data_r;
  logic               rd_vld_r;
  logic [WB-1:0]      mn_r;
  logic [MV_BITS-1:0] mx_r;
  logic [1:0]         cnt_r;
  logic [6:0]         level_r;

  logic in_acc, rd_en, fin_go, out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_acc   = in_valid && !in_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:  if (scan_cnt_r == LAST_IDX) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_FIN;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    fin_go   = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_stall = 1'b0;
      ST_SCAN:  rd_en = 1'b1;
      ST_DRAIN: ;
      ST_FIN:   fin_go = out_free;
      default:  ;
    endcase
  end

  // sample memory: one write port, one registered read port
  logic [MV_BITS-1:0] win_mem [WINDOW_DEPTH];

  always_ff @(posedge clk) begin
    if (in_acc) win_mem[ptr_r] <= in_battery_mv;
    if (rd_en) rd_data_r <= win_mem[scan_cnt_r];
  end

  // finalize: rapid check, verdict, presence, charging
  logic [MV_BITS-1:0] diff;
  logic [31:0]        elapsed;
  logic               big, in_win, rapid, judge, stable_s, present, charging;
  logic [WB-1:0]      spread, v_w, usb_w;
  logic [MV_BITS-1:0] ls_a, ls_nxt;
  logic [7:0]         run_a, run_nxt;
  logic               link_a, link_nxt, verdict;
  logic [31:0]        last_jump_nxt;
  status_t            status;

  always_comb begin
    v_w     = WB'(v_r);
    usb_w   = WB'(usb_r);
    diff    = (v_r > last_stable_r) ? v_r - last_stable_r : last_stable_r - v_r;
    big     = (last_stable_r != '0) && (WB'(diff) > WB'(rapid_change_r));
    elapsed = now_r - last_jump_r;
    in_win  = elapsed < {16'd0, rapid_window_r};
    rapid   = big && in_win;
    last_jump_nxt = (big && !in_win) ? now_r : last_jump_r;
    ls_a    = (last_stable_r == '0) ? v_r : last_stable_r;

    judge    = (cnt_r == 2'd3);
    spread   = (WB'(mx_r) >= mn_r) ? WB'(mx_r) - mn_r : '0;
    stable_s = (spread <= WB'(spread_tol_r)) && !rapid;

    run_a  = run_r;
    ls_nxt = ls_a;
    link_a = link_r;
    if (judge) begin
      if (stable_s) begin
        run_a  = 8'd0;
        ls_nxt = v_r;
      end else if (run_r != RUN_MAX) begin
        run_a = run_r + 8'd1;
      end
      link_a = run_a < inst_limit_r;
    end
    verdict = judge ? link_a : 1'b1;

    present  = (v_w >= WB'(present_min_r)) && (v_w <= WB'(present_max_r));
    charging = (usb_w >= WB'(usb_present_r)) && (v_w >= WB'(charging_mv_r));
    run_nxt  = run_a;
    link_nxt = link_a;
    if (!present) begin
      run_nxt  = 8'd0;
      link_nxt = 1'b1;
      ls_nxt   = '0;
    end

    if (!present)       status = STATUS_DISCONNECTED;
    else if (!link_nxt) status = STATUS_UNSTABLE;
    else if (charging)  status = STATUS_CHARGING;
    else                status = STATUS_CONNECTED;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      ptr_r         <= '0;
      scan_cnt_r    <= '0;
      vbits_r       <= '0;
      rd_pend_r     <= 1'b0;
      last_stable_r <= '0;
      last_jump_r   <= '0;
      run_r         <= '0;
      link_r        <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_en;
      if (in_acc) begin
        vbits_r[ptr_r] <= 1'b1;
        ptr_r          <= (ptr_r == LAST_IDX) ? '0 : ptr_r + 1'b1;
        scan_cnt_r     <= '0;
      end else if (rd_en) begin
        scan_cnt_r <= scan_cnt_r + 1'b1;
      end
      if (fin_go) begin
        last_stable_r <= ls_nxt;
        last_jump_r   <= last_jump_nxt;
        run_r         <= run_nxt;
        link_r        <= link_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  logic [WB-1:0] s_w;
  assign s_w = rd_vld_r ? WB'(rd_data_r) : '0;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      v_r   <= in_battery_mv;
      usb_r <= in_usb_mv;
      now_r <= in_now_ms;
      mn_r  <= WB'(SCAN_MIN_START);
      mx_r  <= '0;
      cnt_r <= 2'd0;
    end else if (rd_pend_r && (s_w != '0)) begin
      // empty slots read as zero and are skipped
      if (cnt_r != 2'd3) cnt_r <= cnt_r + 2'd1;
      if (s_w < mn_r) mn_r <= s_w;
      if (rd_data_r > mx_r) mx_r <= rd_data_r;
    end
    if (rd_en) begin
      rd_vld_r <= vbits_r[scan_cnt_r];
      level_r  <= level_of(16'(v_r));
    end
    if (fin_go) begin
      out_present       <= present;
      out_level_percent <= present ? level_r : 7'd0;
      out_sample_stable <= verdict;
      out_rapid_change  <= rapid;
      out_charging      <= charging;
      out_status        <= status;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> design/bslm_checker.sv
// bslm_checker: port-level checks of the battery monitor request and result channels
// depends on bslm_pkg; bound to battery_stability_and_level_monitor_core
module bslm_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic                                 out_present,
  input logic [6:0]                           out_level_percent,
  input logic                                 out_charging,
  input bslm_pkg::status_t                    out_status
);
  import bslm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_level_percent) && $stable(out_present))
    else $error("stalled result changed");

  // one request in flight: busy right after acceptance
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous one in flight");

  // absent battery gives zero level and disconnected status
  a_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_present |->
      out_level_percent == 7'd0 && out_status == STATUS_DISCONNECTED)
    else $error("absent battery reported with level or status");

  // status agrees with presence and charging, and the level stays within LEVEL_MAX
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_present |-> out_status != STATUS_DISCONNECTED
      && out_level_percent <= LEVEL_MAX
      && (out_status != STATUS_CHARGING || out_charging))
    else $error("status inconsistent with flags");

endmodule

bind battery_stability_and_level_monitor_core bslm_checker u_bslm_checker (.*);

>>> sim/tb_battery_stability_and_level_monitor_core.sv
// tb_battery_stability_and_level_monitor_core: self-checking bench for the battery monitor
// drives samples under random bursts and output stalls, predicts every reading in-bench
// depends on bslm_pkg and battery_stability_and_level_monitor_core
module tb_battery_stability_and_level_monitor_core;
  import bslm_pkg::*;

  localparam int DEPTH      = 8;
  localparam int MV_W       = 13;
  localparam int SCAN_START = 4300;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [MV_W-1:0] battery;
    logic [MV_W-1:0] usb;
    logic [31:0]     now;
  } sample_t;

  typedef struct packed {
    logic       present;
    logic [6:0] level;
    logic       stable;
    logic       rapid;
    logic       charging;
    status_t    status;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [MV_W-1:0] in_battery_mv = '0;
  logic [MV_W-1:0] in_usb_mv = '0;
  logic [31:0] in_now_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_present;
  logic [6:0] out_level_percent;
  logic out_sample_stable;
  logic out_rapid_change;
  logic out_charging;
  status_t out_status;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  battery_stability_and_level_monitor_core #(
    .WINDOW_DEPTH(DEPTH),
    .MV_BITS(MV_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_battery_mv(in_battery_mv),
    .in_usb_mv(in_usb_mv),
    .in_now_ms(in_now_ms),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_present(out_present),
    .out_level_percent(out_level_percent),
    .out_sample_stable(out_sample_stable),
    .out_rapid_change(out_rapid_change),
    .out_charging(out_charging),
    .out_status(out_status),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // monitor settings as the block should hold them
  logic [12:0] lim_rapid, lim_spread, lim_pmin, lim_pmax, lim_usb, lim_chg;
  logic [15:0] lim_window;
  logic [7:0]  lim_unstable;

  // tracking state of the monitor
  logic [MV_W-1:0] win [DEPTH];
  int              wr_ptr;
  logic [MV_W-1:0] ref_mv;
  logic [31:0]     jump_ms;
  logic [7:0]      run;
  logic            link_ok;

  sample_t  pending_samples[$];
  reading_t expected_readings[$];
  sample_t  offered;
  reading_t want;
  logic [31:0] clock_ms = '0;

  int mismatches = 0;
  int requests_sent = 0;
  int readings_seen = 0;
  int settings_used = 1;
  int input_stall_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  int holds_done = 0;

  function automatic logic [6:0] level_pct(input logic [MV_W-1:0] mv);
    int x;
    int p;
    x = int'(mv);
    if (x >= 4150) p = 95 + (x - 4150) / 10;
    else if (x >= 4000) p = 75 + ((x - 4000) * 2) / 15;
    else if (x >= 3800) p = 50 + (x - 3800) / 8;
    else if (x >= 3600) p = 25 + (x - 3600) / 8;
    else if (x >= 3400) p = 10 + ((x - 3400) * 3) / 40;
    else if (x >= 3200) p = 5 + (x - 3200) / 40;
    else if (x >= 3000) p = (x - 3000) / 40;
    else p = 0;
    if (p > 100) p = 100;
    return p[6:0];
  endfunction

  function automatic reading_t judge_sample(input sample_t s);
    reading_t r;
    logic [MV_W-1:0] v;
    logic [MV_W-1:0] lo;
    logic [MV_W-1:0] hi;
    logic [MV_W-1:0] diff_mv;
    logic [31:0] elapsed;
    int count;
    logic rapid;
    r = '0;
    rapid = 1'b0;
    v = s.battery;
    win[wr_ptr] = v;
    wr_ptr = (wr_ptr + 1) % DEPTH;
    if (ref_mv == '0) begin
      ref_mv = v;
    end else begin
      diff_mv = (v > ref_mv) ? v - ref_mv : ref_mv - v;
      if (diff_mv > lim_rapid) begin
        elapsed = s.now - jump_ms;
        if (elapsed < {16'd0, lim_window}) rapid = 1'b1;
        else jump_ms = s.now;
      end
    end
    // zero slots are empty, the scan minimum starts at a fixed ceiling
    count = 0;
    lo = SCAN_START[MV_W-1:0];
    hi = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (win[k] != '0) begin
        count++;
        if (win[k] < lo) lo = win[k];
        if (win[k] > hi) hi = win[k];
      end
    end
    if (count < 3) begin
      r.stable = 1'b1;
    end else begin
      if (((hi >= lo) ? hi - lo : '0) <= lim_spread && !rapid) begin
        run = '0;
        ref_mv = v;
      end else if (run != 8'd255) begin
        run = run + 8'd1;
      end
      link_ok = run < lim_unstable;
      r.stable = link_ok;
    end
    r.rapid = rapid;
    r.present = v >= lim_pmin && v <= lim_pmax;
    if (r.present) begin
      r.level = level_pct(v);
    end else begin
      r.level = '0;
      run = '0;
      link_ok = 1'b1;
      ref_mv = '0;
    end
    r.charging = s.usb >= lim_usb && v >= lim_chg;
    if (!r.present) r.status = STATUS_DISCONNECTED;
    else if (!link_ok) r.status = STATUS_UNSTABLE;
    else if (r.charging) r.status = STATUS_CHARGING;
    else r.status = STATUS_CONNECTED;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int exp_val);
    $display("mismatch at %0t, reading %0d: %s got %0d expected %0d",
             $time, readings_seen, field, got, exp_val);
    mismatches++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_RAPID_CHANGE:     lim_rapid = data[12:0];
      REG_RAPID_WINDOW:     lim_window = data;
      REG_SPREAD_TOLERANCE: lim_spread = data[12:0];
      REG_INSTABILITY_LIM:  lim_unstable = data[7:0];
      REG_PRESENT_MIN:      lim_pmin = data[12:0];
      REG_PRESENT_MAX:      lim_pmax = data[12:0];
      REG_USB_PRESENT:      lim_usb = data[12:0];
      REG_CHARGING:         lim_chg = data[12:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [15:0] rapid_mv, window_ms, spread_mv, limit,
                              pmin, pmax, usb_mv, chg_mv);
    write_reg(REG_RAPID_CHANGE, rapid_mv);
    write_reg(REG_RAPID_WINDOW, window_ms);
    write_reg(REG_SPREAD_TOLERANCE, spread_mv);
    write_reg(REG_INSTABILITY_LIM, limit);
    write_reg(REG_PRESENT_MIN, pmin);
    write_reg(REG_PRESENT_MAX, pmax);
    write_reg(REG_USB_PRESENT, usb_mv);
    write_reg(REG_CHARGING, chg_mv);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // mostly in a plausible range, sometimes any 16-bit pattern
  function automatic logic [15:0] pick(input int lo, input int hi);
    if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 16'hFFFF));
    return 16'($urandom_range(lo, hi));
  endfunction

  task automatic add_sample(input int bat, input int usb, input int unsigned dt);
    sample_t s;
    if (bat < 0) bat = 0;
    if (bat > 8191) bat = 8191;
    clock_ms = clock_ms + dt;
    s.battery = bat[MV_W-1:0];
    s.usb = usb[MV_W-1:0];
    s.now = clock_ms;
    pending_samples.push_back(s);
  endtask

  // runs of related samples: steady, noisy, jumping, absent, high, odd timing
  task automatic add_random(input int total);
    int kind;
    int len;
    int base;
    int spread;
    int bat;
    int usb;
    int unsigned dt;
    while (total > 0) begin
      kind = $urandom_range(0, 9);
      len = $urandom_range(3, 24);
      base = $urandom_range(int'(lim_pmin), int'(lim_pmax));
      spread = $urandom_range(0, 250);
      repeat (len) begin
        case (kind)
          0, 1:    bat = base;
          2, 3, 4: bat = base + $urandom_range(0, spread);
          5:       bat = base + $urandom_range(0, 3000) - 1500;
          6:       bat = $urandom_range(0, 8191);
          7: begin
            case ($urandom_range(0, 2))
              0: bat = 0;
              1: bat = $urandom_range(0, 2600);
              default: bat = $urandom_range(4400, 8191);
            endcase
          end
          8:       bat = $urandom_range(4250, 8191);
          default: bat = base + $urandom_range(0, 100);
        endcase
        if ($urandom_range(0, 1) == 0) usb = $urandom_range(3900, 4200);
        else usb = $urandom_range(0, 8191);
        if (kind == 9) dt = ($urandom_range(0, 1) == 0) ? $urandom() : 0;
        else if ($urandom_range(0, 9) == 0) dt = $urandom_range(3000, 70000);
        else dt = $urandom_range(0, 3000);
        add_sample(bat, usb, dt);
        total--;
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_valid || expected_readings.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // request driver: bursts of random length, random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_readings.push_back(judge_sample(offered));
        requests_sent++;
      end
      if (in_valid && in_stall) input_stall_cycles++;
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          offered = pending_samples.pop_front();
          in_battery_mv <= offered.battery;
          in_usb_mv <= offered.usb;
          in_now_ms <= offered.now;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with two long hold-offs so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if ((holds_done == 0 && requests_sent >= 200) ||
                 (holds_done == 1 && requests_sent >= 600)) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        2: out_stall <= ($urandom_range(0, 99) < 70);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected reading", 1, 0);
      end else begin
        want = expected_readings.pop_front();
        if (out_present !== want.present)
          report_mismatch("present", out_present, want.present);
        if (out_level_percent !== want.level)
          report_mismatch("level_percent", out_level_percent, want.level);
        if (out_sample_stable !== want.stable)
          report_mismatch("sample_stable", out_sample_stable, want.stable);
        if (out_rapid_change !== want.rapid)
          report_mismatch("rapid_change", out_rapid_change, want.rapid);
        if (out_charging !== want.charging)
          report_mismatch("charging", out_charging, want.charging);
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        readings_seen++;
      end
    end
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d readings outstanding", expected_readings.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    lim_rapid = 13'd300;
    lim_window = 16'd5000;
    lim_spread = 13'd200;
    lim_unstable = 8'd3;
    lim_pmin = 13'd2500;
    lim_pmax = 13'd4500;
    lim_usb = 13'd4000;
    lim_chg = 13'd4100;
    for (int k = 0; k < DEPTH; k++) win[k] = '0;
    wr_ptr = 0;
    ref_mv = '0;
    jump_ms = '0;
    run = '0;
    link_ok = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset settings: settle, jumps inside and outside the window
    add_sample(3700, 0, 10);
    add_sample(3700, 4000, 10);
    add_sample(3750, 3999, 10);
    add_sample(4100, 4000, 10);
    add_sample(4099, 4000, 6000);
    add_sample(4150, 8191, 10);
    add_sample(4200, 4000, 10);
    // absent, empty slot and presence edges
    add_sample(8191, 8191, 10);
    add_sample(0, 0, 10);
    add_sample(2499, 0, 10);
    add_sample(2500, 0, 10);
    add_sample(4500, 0, 10);
    add_sample(4501, 0, 10);
    // level segment boundaries
    add_sample(2999, 4000, 1);
    add_sample(3000, 4000, 1);
    add_sample(3200, 4000, 1);
    add_sample(3400, 4000, 1);
    add_sample(3600, 4000, 1);
    add_sample(3800, 4000, 1);
    add_sample(4000, 4000, 1);
    add_sample(4149, 4000, 1);
    // readings at and above the scan ceiling, then timestamp wrap
    add_sample(4300, 4000, 10);
    add_sample(4400, 4000, 10);
    clock_ms = 32'hFFFF_FFF0;
    add_sample(4400, 4100, 20);
    add_sample(4410, 0, 5);
    add_random(100);
    wait_idle();

    program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    add_random(50);
    wait_idle();

    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'hFFFF, 16'hFFFF);
    add_random(50);
    wait_idle();

    program_regs(16'd0, 16'd65535, 16'd8191, 16'd1, 16'd0, 16'd8191, 16'd0, 16'd0);
    add_random(60);
    wait_idle();

    // zero tolerance and the widest limit drive the unstable counter into saturation
    program_regs(16'd8191, 16'd0, 16'd0, 16'd255, 16'd0, 16'd8191, 16'd4000, 16'd4100);
    add_random(260);
    wait_idle();

    repeat (4) begin
      program_regs(pick(0, 1000), pick(0, 20000), pick(0, 500), pick(0, 10),
                   pick(2000, 3500), pick(3800, 5000), pick(3500, 4500), pick(3800, 4300));
      add_random(40);
      wait_idle();
    end

    $display("checked %0d readings from %0d requests across %0d register settings",
             readings_seen, requests_sent, settings_used);
    $display("request side held off for %0d cycles, %0d long output hold-offs",
             input_stall_cycles, holds_done);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
